// ===== sv/ntc_pkg.sv =====
package ntc_pkg;

    localparam int TableLen = 24;
    localparam int AngleW   = 28;   // 2^-16 degree units, holds +-(180+100)*2^16
    localparam int VecW     = 40;   // vector components, 11 bit value times 2^16 plus growth

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_roll_init,
        t_st_roll_iter,
        t_st_sqrt,
        t_st_pitch_init,
        t_st_pitch_iter,
        t_st_ctl_roll,
        t_st_ctl_pitch,
        t_st_done
    } t_state;

    localparam logic [2:0] RegZeroX   = 3'd0;
    localparam logic [2:0] RegZeroY   = 3'd1;
    localparam logic [2:0] RegZeroZ   = 3'd2;
    localparam logic [2:0] RegRadius  = 3'd3;
    localparam logic [2:0] RegCtlAng  = 3'd4;

    function automatic logic [AngleW-1:0] atan_entry(input logic [4:0] i);
        logic [AngleW-1:0] v;
        begin
            case (i)
                5'd0:  v = 28'd2949120;
                5'd1:  v = 28'd1740967;
                5'd2:  v = 28'd919879;
                5'd3:  v = 28'd466945;
                5'd4:  v = 28'd234379;
                5'd5:  v = 28'd117304;
                5'd6:  v = 28'd58666;
                5'd7:  v = 28'd29335;
                5'd8:  v = 28'd14668;
                5'd9:  v = 28'd7334;
                5'd10: v = 28'd3667;
                5'd11: v = 28'd1833;
                5'd12: v = 28'd917;
                5'd13: v = 28'd458;
                5'd14: v = 28'd229;
                5'd15: v = 28'd115;
                5'd16: v = 28'd57;
                5'd17: v = 28'd29;
                5'd18: v = 28'd14;
                5'd19: v = 28'd7;
                5'd20: v = 28'd4;
                5'd21: v = 28'd2;
                5'd22: v = 28'd1;
                default: v = 28'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== sv/ntc_cordic.sv =====
// Vectoring CORDIC: one micro-rotation per cycle on a single shift/add unit.
module ntc_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ntc_pkg::VecW-1:0] i_y,
    input  logic signed [ntc_pkg::VecW-1:0] i_x,
    output logic                          o_done,
    output logic signed [8:0]             o_deg
);
    localparam int StepCap = (CORDIC_STEPS < ntc_pkg::TableLen) ? CORDIC_STEPS
                                                                : ntc_pkg::TableLen;

    logic signed [ntc_pkg::VecW-1:0]   r_x, r_y, n_x, n_y, sx, sy;
    logic signed [ntc_pkg::AngleW-1:0] r_z, n_z, zq;
    logic [4:0]                        r_i, n_i;
    logic                              r_busy, n_busy, r_done, n_done;
    logic signed [8:0]                 r_deg, n_deg;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i;
        n_busy = r_busy; n_done = 1'b0; n_deg = r_deg;
        sx = r_x >>> r_i;
        sy = r_y >>> r_i;
        // Truncation toward zero of the angle in whole degrees.
        zq = (r_z < 0) ? -((-r_z) >>> 16) : (r_z >>> 16);
        if (i_start) begin
            n_i = '0;
            n_z = '0;
            n_busy = 1'b0;
            if (i_y == 0 && i_x == 0) begin
                n_deg = 9'sd0; n_done = 1'b1;
            end else if (i_y == 0) begin
                n_deg = (i_x > 0) ? 9'sd0 : 9'sd180; n_done = 1'b1;
            end else if (i_x == 0) begin
                n_deg = (i_y > 0) ? 9'sd90 : -9'sd90; n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                if (i_x < 0) begin
                    n_x = -i_x; n_y = -i_y;
                    n_z = (i_y > 0) ? ntc_pkg::AngleW'(180 * 65536)
                                    : -ntc_pkg::AngleW'(180 * 65536);
                end else begin
                    n_x = i_x; n_y = i_y;
                end
            end
        end else if (r_busy) begin
            if (r_y == 0 || 32'(r_i) >= StepCap) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (zq > 180) n_deg = 9'sd180;
                else if (zq < -180) n_deg = -9'sd180;
                else n_deg = 9'(zq);
            end else begin
                if (r_y > 0) begin
                    n_x = r_x + sy; n_y = r_y - sx;
                    n_z = r_z + ntc_pkg::atan_entry(r_i);
                end else begin
                    n_x = r_x - sy; n_y = r_y + sx;
                    n_z = r_z - ntc_pkg::atan_entry(r_i);
                end
                n_i = r_i + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i; r_deg <= n_deg;
    end

    assign o_done = r_done;
    assign o_deg  = r_deg;
endmodule

// ===== sv/ntc_isqrt.sv =====
// Bit-pair restoring square root of i_val * 2^32, one result bit per cycle.
// The root carries ten integer bits and 16 fraction bits.
module ntc_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_val,
    output logic        o_done,
    output logic [25:0] o_root
);
    logic [19:0] r_rem;
    logic [25:0] r_root;
    logic [26:0] r_part, n_part;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [28:0] acc;
    logic [27:0] trial;
    logic        take;

    // Once the ten integer pairs are used up, zero pairs shift in for the fraction.
    always_comb begin
        acc    = {r_part, r_rem[19:18]};
        trial  = {r_root, 2'b01};
        take   = (acc >= {1'b0, trial});
        n_part = take ? 27'(acc - {1'b0, trial}) : 27'(acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
        if (i_start) begin
            r_rem  <= i_val;
            r_root <= '0;
            r_part <= '0;
            r_cnt  <= 5'd26;
        end else if (r_busy) begin
            r_rem  <= {r_rem[17:0], 2'b00};
            r_root <= {r_root[24:0], take};
            r_part <= n_part;
            r_cnt  <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== sv/nunchuk_tilt_to_control_top.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | i_valid / o_stall   | stick, accel high bytes, extra bits
// out     | output    | o_valid / i_stall   | controls, relative angles, accelerations
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// o_valid rises after two CORDIC passes, a square root and two divisions for the
// control scaling, all run one after another by the sequencer.
// A zero or saturated Y skips the square root and the pitch pass.
// Reset is synchronous and restores the offsets and clears the reference angles.
// The input is stalled from acceptance until the result has been taken.
module nunchuk_tilt_to_control_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_stick_x,
    input  logic [7:0]        i_stick_y,
    input  logic [7:0]        i_accel_x_high,
    input  logic [7:0]        i_accel_y_high,
    input  logic [7:0]        i_accel_z_high,
    input  logic [7:0]        i_extra_bits,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [9:0]        o_roll_control,
    output logic [9:0]        o_pitch_control,
    output logic [9:0]        o_stick_x_control,
    output logic [9:0]        o_stick_y_control,
    output logic signed [8:0] o_roll_relative,
    output logic signed [8:0] o_pitch_relative,
    output logic signed [10:0] o_accel_x,
    output logic signed [10:0] o_accel_y,
    output logic signed [10:0] o_accel_z,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [9:0]        i_cfg_data
);
    ntc_pkg::t_state r_st, n_st;

    logic [9:0] r_zx, r_zy, r_zz, r_rad;
    logic [7:0] r_ca;
    logic signed [8:0] r_ref_roll, r_ref_pitch, r_roll, r_pitch;
    logic signed [10:0] r_ax, r_ay, r_az;
    logic [7:0] r_sx, r_sy;
    logic r_rel;
    logic signed [8:0] r_rr, r_pr;
    logic [9:0] r_rc, r_pc;
    logic [8:0] r_dr;
    logic [9:0] r_dn, r_dq;
    logic [3:0] r_dcnt;

    logic cor_start, cor_done, sq_start, sq_done;
    logic signed [ntc_pkg::VecW-1:0] cor_y, cor_x;
    logic signed [8:0] cor_deg;
    logic [25:0] sq_root;
    logic [19:0] sq_val;

    logic acc_in;
    assign acc_in = i_valid && !o_stall;

    ntc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_y(cor_y), .i_x(cor_x), .o_done(cor_done), .o_deg(cor_deg)
    );

    ntc_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_val(sq_val), .o_done(sq_done), .o_root(sq_root)
    );

    logic [10:0] ay_abs;
    logic pitch_sat;
    assign ay_abs    = r_ay[10] ? 11'(-r_ay) : 11'(r_ay);
    assign pitch_sat = ay_abs >= {1'b0, r_rad};
    assign sq_val    = 20'(32'(r_rad) * 32'(r_rad) - 32'(ay_abs) * 32'(ay_abs));

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ntc_pkg::t_st_idle:       if (acc_in) n_st = ntc_pkg::t_st_roll_init;
            ntc_pkg::t_st_roll_init:  n_st = ntc_pkg::t_st_roll_iter;
            ntc_pkg::t_st_roll_iter: begin
                if (cor_done) begin
                    if (r_ay == 0 || pitch_sat) n_st = ntc_pkg::t_st_ctl_roll;
                    else n_st = ntc_pkg::t_st_sqrt;
                end
            end
            ntc_pkg::t_st_sqrt:       if (sq_done) n_st = ntc_pkg::t_st_pitch_init;
            ntc_pkg::t_st_pitch_init: n_st = ntc_pkg::t_st_pitch_iter;
            ntc_pkg::t_st_pitch_iter: if (cor_done) n_st = ntc_pkg::t_st_ctl_roll;
            ntc_pkg::t_st_ctl_roll:   if (r_dcnt == 4'd10) n_st = ntc_pkg::t_st_ctl_pitch;
            ntc_pkg::t_st_ctl_pitch:  if (r_dcnt == 4'd10) n_st = ntc_pkg::t_st_done;
            ntc_pkg::t_st_done:       if (!i_stall) n_st = ntc_pkg::t_st_idle;
            default:                  n_st = ntc_pkg::t_st_idle;
        endcase
    end

    // Outputs of the sequencer.
    logic r_sq_go;
    always_comb begin
        cor_start = 1'b0;
        sq_start  = 1'b0;
        cor_y = '0;
        cor_x = '0;
        unique case (r_st)
            ntc_pkg::t_st_roll_init: begin
                cor_start = 1'b1;
                cor_y = ntc_pkg::VecW'(r_ax) <<< 16;
                cor_x = ntc_pkg::VecW'(r_az) <<< 16;
            end
            ntc_pkg::t_st_pitch_init: begin
                cor_start = 1'b1;
                cor_y = ntc_pkg::VecW'(r_ay) <<< 16;
                cor_x = $signed({14'd0, sq_root});
            end
            ntc_pkg::t_st_sqrt: sq_start = r_sq_go;
            default: ;
        endcase
    end

    // Relative angle, wrap and control scaling on shared logic.
    logic signed [8:0] cur_ang, cur_ref, rel;
    logic signed [10:0] diff;
    logic [7:0] c_eff;
    logic signed [9:0] a_cl;
    logic [18:0] num;
    logic [8:0] den;
    always_comb begin
        cur_ang = (r_st == ntc_pkg::t_st_ctl_roll) ? r_roll : r_pitch;
        cur_ref = (r_st == ntc_pkg::t_st_ctl_roll) ? r_ref_roll : r_ref_pitch;
        if (r_rel) cur_ref = cur_ang;
        diff = 11'(cur_ang) - 11'(cur_ref);
        if (diff < -11'sd180) diff = diff + 11'sd360;
        if (diff > 11'sd180) diff = diff - 11'sd360;
        rel = 9'(diff);
        c_eff = (r_ca == 8'd0) ? 8'd1 : r_ca;
        a_cl = 10'(rel);
        if (a_cl < -$signed({2'b0, c_eff})) a_cl = -$signed({2'b0, c_eff});
        if (a_cl > $signed({2'b0, c_eff})) a_cl = $signed({2'b0, c_eff});
        num = 19'(10'(a_cl + $signed({2'b0, c_eff}))) * 19'd1023;
        den = {c_eff, 1'b0};
    end

    // Restoring division, one quotient bit per cycle. The quotient never exceeds
    // 1023, so the top nine numerator bits already sit below the divisor.
    logic [9:0] dtrial, dsub, q_nx;
    logic dge;
    always_comb begin
        dtrial = {r_dr, r_dn[9]};
        dge    = dtrial >= {1'b0, den};
        dsub   = dge ? dtrial - {1'b0, den} : dtrial;
        q_nx   = {r_dq[8:0], dge};
    end

    logic in_ctl;
    assign in_ctl = (r_st == ntc_pkg::t_st_ctl_roll) || (r_st == ntc_pkg::t_st_ctl_pitch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ntc_pkg::t_st_idle;
            r_zx <= 10'd510; r_zy <= 10'd490; r_zz <= 10'd460;
            r_rad <= 10'd210; r_ca <= 8'd30;
            r_ref_roll <= '0; r_ref_pitch <= '0;
            r_sq_go <= 1'b0;
            r_dcnt <= 4'd0;
        end else begin
            r_st <= n_st;
            r_sq_go <= (r_st != ntc_pkg::t_st_sqrt) && (n_st == ntc_pkg::t_st_sqrt);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ntc_pkg::RegZeroX:  r_zx  <= i_cfg_data;
                    ntc_pkg::RegZeroY:  r_zy  <= i_cfg_data;
                    ntc_pkg::RegZeroZ:  r_zz  <= i_cfg_data;
                    ntc_pkg::RegRadius: r_rad <= i_cfg_data;
                    ntc_pkg::RegCtlAng: r_ca  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_st == ntc_pkg::t_st_ctl_pitch && r_rel) begin
                r_ref_roll  <= r_roll;
                r_ref_pitch <= r_pitch;
            end
            if (in_ctl) begin
                r_dcnt <= (r_dcnt == 4'd10) ? 4'd0 : r_dcnt + 4'd1;
            end
        end
        if (acc_in) begin
            r_ax <= 11'({i_accel_x_high, i_extra_bits[3:2]}) - 11'(r_zx);
            r_ay <= 11'({i_accel_y_high, i_extra_bits[5:4]}) - 11'(r_zy);
            r_az <= 11'({i_accel_z_high, i_extra_bits[7:6]}) - 11'(r_zz);
            r_sx <= i_stick_x; r_sy <= i_stick_y;
            r_rel <= i_extra_bits[0];
        end
        if (r_st == ntc_pkg::t_st_roll_iter && cor_done) begin
            r_roll <= cor_deg;
            if (r_ay == 0) r_pitch <= 9'sd0;
            else if (pitch_sat) r_pitch <= r_ay[10] ? -9'sd90 : 9'sd90;
        end
        if (r_st == ntc_pkg::t_st_pitch_iter && cor_done) r_pitch <= cor_deg;
        if (in_ctl) begin
            if (r_dcnt == 4'd0) begin
                r_dr <= num[18:10];
                r_dn <= num[9:0];
                r_dq <= '0;
            end else begin
                r_dr <= dsub[8:0];
                r_dn <= {r_dn[8:0], 1'b0};
                r_dq <= q_nx;
            end
        end
        if (r_st == ntc_pkg::t_st_ctl_roll) begin
            r_rr <= rel;
            if (r_dcnt == 4'd10) r_rc <= q_nx;
        end
        if (r_st == ntc_pkg::t_st_ctl_pitch) begin
            r_pr <= rel;
            if (r_dcnt == 4'd10) r_pc <= q_nx;
        end
    end

    // 1023*s/255 is exactly 4*s + s/85 for s in 0..255, and s/85 is a few compares.
    logic [1:0] sx_q, sy_q;
    assign sx_q = (r_sx == 8'd255) ? 2'd3 : (r_sx >= 8'd170) ? 2'd2 :
                  (r_sx >= 8'd85) ? 2'd1 : 2'd0;
    assign sy_q = (r_sy == 8'd255) ? 2'd3 : (r_sy >= 8'd170) ? 2'd2 :
                  (r_sy >= 8'd85) ? 2'd1 : 2'd0;
    assign o_stick_x_control = {r_sx, 2'b00} + {8'd0, sx_q};
    assign o_stick_y_control = {r_sy, 2'b00} + {8'd0, sy_q};
    assign o_roll_control    = r_rc;
    assign o_pitch_control   = r_pc;
    assign o_roll_relative   = r_rr;
    assign o_pitch_relative  = r_pr;
    assign o_accel_x = r_ax;
    assign o_accel_y = r_ay;
    assign o_accel_z = r_az;
    assign o_valid   = (r_st == ntc_pkg::t_st_done);
    assign o_stall   = (r_st != ntc_pkg::t_st_idle);
    assign o_cfg_ready = (r_st == ntc_pkg::t_st_idle);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while input open");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped under stall");
    a_ctl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_relative <= 9'sd180 && o_roll_relative >= -9'sd180))
        else $error("relative roll out of range");
endmodule

// ===== bench/nunchuk_tilt_to_control_top_test.sv =====
`timescale 1ns / 1ps

module nunchuk_tilt_to_control_top_test;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_RANDOM    = 1130;

    typedef struct packed {
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] xh;
        logic [7:0] yh;
        logic [7:0] zh;
        logic [7:0] ex;
    } t_report;

    typedef struct packed {
        logic [9:0]         roll_ctl;
        logic [9:0]         pitch_ctl;
        logic [9:0]         sx_ctl;
        logic [9:0]         sy_ctl;
        logic signed [8:0]  roll_rel;
        logic signed [8:0]  pitch_rel;
        logic signed [10:0] ax;
        logic signed [10:0] ay;
        logic signed [10:0] az;
    } t_control;

    // Directed rows: the expected word is only typed in where it is obvious.
    typedef struct {
        t_report  rep;
        bit       has_known;
        t_control known;
    } t_tilt_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [7:0] i_stick_x = '0, i_stick_y = '0;
    logic [7:0] i_accel_x_high = '0, i_accel_y_high = '0, i_accel_z_high = '0;
    logic [7:0] i_extra_bits = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [9:0] o_roll_control, o_pitch_control, o_stick_x_control, o_stick_y_control;
    logic signed [8:0] o_roll_relative, o_pitch_relative;
    logic signed [10:0] o_accel_x, o_accel_y, o_accel_z;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [9:0] i_cfg_data = '0;

    nunchuk_tilt_to_control_top DUT (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state.
    logic [9:0] off_x, off_y, off_z, radius;
    logic [7:0] span;
    int ref_roll, ref_pitch;

    t_control expected_q[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   send_idle_pct = 0, recv_idle_pct = 0;
    bit   hold_recv = 1'b0;
    bit   stim_done = 1'b0;
    t_tilt_row rows[$];

    const longint AtanTab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
        1, 0};

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int vector_angle(longint y, longint x);
        longint z, xo;
        z = 0;
        if (y == 0 && x == 0) return 0;
        if (y == 0) return x > 0 ? 0 : 180;
        if (x == 0) return y > 0 ? 90 : -90;
        if (x < 0) begin
            z = (y > 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xo = x;
            if (y == 0) break;
            if (y > 0) begin
                x += asr(y, i);
                y -= asr(xo, i);
                z += AtanTab[i];
            end else begin
                x -= asr(y, i);
                y += asr(xo, i);
                z -= AtanTab[i];
            end
        end
        z = z / 65536;
        if (z > 180) z = 180;
        if (z < -180) z = -180;
        return int'(z);
    endfunction

    function automatic int wrap180(int d);
        if (d < -180) d += 360;
        if (d > 180) d -= 360;
        return d;
    endfunction

    function automatic logic [9:0] angle_to_span(int a);
        longint c;
        c = (span == 0) ? 1 : span;
        if (a < -c) a = -c;
        if (a > c) a = c;
        return 10'((1023 * (a + c)) / (2 * c));
    endfunction

    function automatic t_control decode_report(t_report r);
        t_control o;
        int ax, ay, az, rad, roll, pitch, rr, pr;
        longint unsigned rest;
        ax = int'({r.xh, r.ex[3:2]}) - int'(off_x);
        ay = int'({r.yh, r.ex[5:4]}) - int'(off_y);
        az = int'({r.zh, r.ex[7:6]}) - int'(off_z);
        rad = radius;
        roll = vector_angle(longint'(ax) * 65536, longint'(az) * 65536);
        if (ay == 0) pitch = 0;
        else if (ay >= rad || -ay >= rad) pitch = ay > 0 ? 90 : -90;
        else begin
            rest = longint'(rad * rad - ay * ay) << 32;
            pitch = vector_angle(longint'(ay) * 65536, int_sqrt(rest));
        end
        if (r.ex[0]) begin
            ref_roll = roll;
            ref_pitch = pitch;
        end
        rr = wrap180(roll - ref_roll);
        pr = wrap180(pitch - ref_pitch);
        o.roll_ctl = angle_to_span(rr);
        o.pitch_ctl = angle_to_span(pr);
        o.sx_ctl = 10'((1023 * int'(r.sx)) / 255);
        o.sy_ctl = 10'((1023 * int'(r.sy)) / 255);
        o.roll_rel = 9'(rr);
        o.pitch_rel = 9'(pr);
        o.ax = 11'(ax);
        o.ay = 11'(ay);
        o.az = 11'(az);
        return o;
    endfunction

    function automatic t_report random_report();
        t_report r;
        r = {$urandom, 16'($urandom)};
        // Keep the button mostly released so relative angles move around.
        r.ex[0] = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) r.yh = 8'(({2'b0, off_y} >> 2) + $urandom_range(0, 6) - 3);
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ntc_pkg::RegZeroX:  off_x = val;
            ntc_pkg::RegZeroY:  off_y = val;
            ntc_pkg::RegZeroZ:  off_z = val;
            ntc_pkg::RegRadius: radius = val;
            ntc_pkg::RegCtlAng: span = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Valid stays up after acceptance until the next word or an idle cycle replaces it;
    // the block keeps its input stalled for far longer than that.
    task automatic send_report(input t_report r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        {i_stick_x, i_stick_y, i_accel_x_high, i_accel_y_high, i_accel_z_high,
            i_extra_bits} <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(decode_report(r));
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic push_row(t_report r, bit known, t_control k);
        t_tilt_row t;
        t.rep = r;
        t.has_known = known;
        t.known = k;
        rows.push_back(t);
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_recv) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_control got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_roll_control, o_pitch_control, o_stick_x_control, o_stick_y_control,
                o_roll_relative, o_pitch_relative, o_accel_x, o_accel_y, o_accel_z};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected output word %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        wait (stim_done == 1'b0 && cycles > 3000);
        hold_recv <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_recv <= 1'b0;
    end

    initial begin
        t_control k;
        t_report r;
        off_x = 510; off_y = 490; off_z = 460; radius = 210; span = 30;
        ref_roll = 0; ref_pitch = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Offsets that land exactly on zero acceleration.
        k = '{roll_ctl: 10'd511, pitch_ctl: 10'd511, sx_ctl: 10'd0, sy_ctl: 10'd1023,
            roll_rel: 9'sd0, pitch_rel: 9'sd0, ax: 11'sd0, ay: 11'sd0, az: 11'sd0};
        push_row('{8'd0, 8'd255, 8'd127, 8'd122, 8'd115, 8'b00_10_10_01}, 1'b1, k);
        k.sx_ctl = 10'd1023; k.sy_ctl = 10'd0;
        push_row('{8'd255, 8'd0, 8'd127, 8'd122, 8'd115, 8'b00_10_10_00}, 1'b1, k);
        push_row('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, 1'b0, k);
        push_row('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFF}, 1'b0, k);
        push_row('{8'd128, 8'd1, 8'd200, 8'd122, 8'd115, 8'b00_10_10_00}, 1'b0, k);
        push_row('{8'd3, 8'd7, 8'd127, 8'd200, 8'd115, 8'b00_10_10_00}, 1'b0, k);
        push_row('{8'd3, 8'd7, 8'd127, 8'd20, 8'd0, 8'b00_10_10_00}, 1'b0, k);
        push_row('{8'd3, 8'd7, 8'd0, 8'd140, 8'd250, 8'b01_01_01_01}, 1'b0, k);
        push_row('{8'd90, 8'd9, 8'd250, 8'd100, 8'd10, 8'b11_00_11_00}, 1'b0, k);
        push_row('{8'd91, 8'd19, 8'd10, 8'd130, 8'd10, 8'b11_00_11_00}, 1'b0, k);
        push_row('{8'd91, 8'd19, 8'd10, 8'd110, 8'd250, 8'b10_01_00_00}, 1'b0, k);
        ref_roll = 0; ref_pitch = 0;
        foreach (rows[i]) begin
            if (rows[i].has_known && decode_report(rows[i].rep) !== rows[i].known) begin
                mismatches++;
                $display("Predictor disagrees with table row %0d", i);
            end
        end
        ref_roll = 0; ref_pitch = 0;
        foreach (rows[i]) send_report(rows[i].rep);
        drain_and_settle();

        // Register extremes and corner settings.
        write_reg(ntc_pkg::RegRadius, 10'd0);
        write_reg(ntc_pkg::RegCtlAng, 10'd0);
        send_report('{8'd1, 8'd2, 8'd127, 8'd200, 8'd115, 8'b00_10_10_00});
        drain_and_settle();
        write_reg(ntc_pkg::RegZeroX, 10'd0);
        write_reg(ntc_pkg::RegZeroY, 10'd1023);
        write_reg(ntc_pkg::RegZeroZ, 10'd0);
        write_reg(ntc_pkg::RegRadius, 10'd1023);
        write_reg(ntc_pkg::RegCtlAng, 10'd255);
        send_report('{8'd5, 8'd6, 8'd255, 8'd0, 8'd0, 8'h01});
        send_report('{8'd5, 8'd6, 8'd0, 8'd255, 8'd255, 8'hFE});
        drain_and_settle();
        write_reg(ntc_pkg::RegZeroX, 10'd1023);
        write_reg(ntc_pkg::RegZeroY, 10'd0);
        write_reg(ntc_pkg::RegZeroZ, 10'd1023);
        write_reg(ntc_pkg::RegRadius, 10'd1);
        write_reg(ntc_pkg::RegCtlAng, 10'd180);
        send_report('{8'd5, 8'd6, 8'd0, 8'd0, 8'd255, 8'h00});
        drain_and_settle();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 16 : 0;
            write_reg(ntc_pkg::RegZeroX, 10'($urandom_range(400, 620)));
            write_reg(ntc_pkg::RegZeroY, 10'($urandom_range(400, 620)));
            write_reg(ntc_pkg::RegZeroZ, 10'($urandom_range(400, 620)));
            write_reg(ntc_pkg::RegRadius, 10'((phase == 2) ? 1023 : $urandom_range(1, 300)));
            write_reg(ntc_pkg::RegCtlAng, 10'((phase == 1) ? 1 : $urandom_range(1, 180)));
            for (int i = 0; i < N_RANDOM / 3; i++) begin
                r = random_report();
                send_report(r);
            end
            drain_and_settle();
        end
        stim_done = 1'b1;
        if (mismatches == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ntc_pkg.sv
sv/ntc_cordic.sv
sv/ntc_isqrt.sv
sv/nunchuk_tilt_to_control_top.sv
bench/nunchuk_tilt_to_control_top_test.sv
